// File: rtl/mcst_pkg.sv
// Package with the shared types, sizes and command codes of the countdown timer table.
package mcst_pkg;

    localparam int TIMER_COUNT = 16;
    localparam int COUNT_WIDTH = 24;
    localparam int STEP_W      = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 72;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_SET     = 2'd1,
        CMD_KILL    = 2'd2,
        CMD_SERVICE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] reload;
        logic [COUNT_WIDTH-1:0] count;
        logic                   run;
        logic                   pend;
    } entry_t;

    typedef struct packed {
        cmd_t                   cmd;
        logic                   hit;
        logic [COUNT_WIDTH-1:0] delay;
        logic                   restart;
    } op_ctrl_t;

endpackage

// File: rtl/mcst_cell.sv
// One timer entry of the rotating table, loaded from its neighbour on every shift.
module mcst_cell
    import mcst_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   shift,
    input  entry_t d,
    output entry_t q
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = shift ? d : entry_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign q = entry_reg;

endmodule

// File: rtl/mcst_op.sv
// Applies the current command to the timer entry leaving the head of the ring.
module mcst_op
    import mcst_pkg::*;
(
    input  op_ctrl_t ctrl,
    input  entry_t   entry_in,
    output entry_t   entry_out,
    output logic     reject
);

    always_comb
    begin
        entry_out = entry_in;
        reject    = 1'b0;
        unique case (ctrl.cmd)
            CMD_TICK:
            begin
                if (entry_in.run)
                begin
                    if (entry_in.count != '0)
                    begin
                        entry_out.count = entry_in.count - 1'b1;
                    end
                    else
                    begin
                        entry_out.pend = 1'b1;
                        entry_out.run  = 1'b0;
                    end
                end
            end
            CMD_SET:
            begin
                if (ctrl.hit)
                begin
                    if (ctrl.delay == '0)
                    begin
                        reject = 1'b1;
                    end
                    else
                    begin
                        entry_out.reload = ctrl.delay;
                        entry_out.count  = ctrl.delay;
                        entry_out.run    = 1'b1;
                    end
                end
            end
            CMD_KILL:
            begin
                if (ctrl.hit)
                begin
                    entry_out = '0;
                end
            end
            CMD_SERVICE:
            begin
                if (ctrl.hit)
                begin
                    if (!entry_in.pend)
                    begin
                        reject = 1'b1;
                    end
                    else
                    begin
                        entry_out.pend = 1'b0;
                        if (ctrl.restart)
                        begin
                            entry_out.count = entry_in.reload;
                            entry_out.run   = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                entry_out = entry_in;
            end
        endcase
    end

endmodule

// File: rtl/multi_channel_software_timer.sv
// Top level of the multi-channel countdown timer table.
//
// Commands arrive on the slave stream (s_tvalid, s_tready, s_tdata); each one
// gives exactly one result transaction on the master stream (m_tvalid,
// m_tready, m_tdata) carrying a status bit and the pending and running masks
// as they stand after the command.
// The timers sit in a ring of TIMER_COUNT cells. A command rotates the ring
// once round, one cell per cycle, and the entry leaving the head cell is
// updated on its way to the tail, so a tick reaches every timer and set, kill
// and service reach the addressed one. A command runs through the run state,
// where the ring turns once round, and then the finish state, which loads
// the result register; a new command is taken only once the block is back
// in idle.
// The result sits in an output register. While the receiver stalls, the next
// command is still accepted and processed; its result then waits, with the
// ring stopped, until the register is free, and no further command is taken.
// Reset clears every timer (reload, count, running and pending) and leaves
// the block idle with no result pending.
module multi_channel_software_timer
    import mcst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // command[1:0], timer_id[6:2], delay_ticks[30:7], restart[31]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status[0], pending_mask[32:1], running_mask[64:33], zeros above
    output logic [OUT_DATA_W-1:0] m_tdata
);

    state_t state_reg;
    state_t state_next;

    logic shift;
    logic load_out;
    logic last_step;
    logic accept;

    cmd_t                   cmd_reg;
    logic [4:0]             id_reg;
    logic [COUNT_WIDTH-1:0] delay_reg;
    logic                   restart_reg;
    logic                   in_range_reg;
    logic                   status_reg;
    logic                   status_next;
    logic [STEP_W-1:0]      step_reg;
    logic [STEP_W-1:0]      step_next;

    logic        out_valid_reg;
    logic        out_status_reg;
    logic [31:0] out_pend_reg;
    logic [31:0] out_run_reg;

    logic [31:0]            delay_wide;
    logic                   id_in_range;
    logic                   op_reject;
    op_ctrl_t               op_ctrl;
    entry_t                 op_out;
    entry_t                 cell_q [TIMER_COUNT];
    logic [TIMER_COUNT-1:0] pend_vec;
    logic [TIMER_COUNT-1:0] run_vec;

    assign accept      = s_tvalid && s_tready;
    assign last_step   = (step_reg == STEP_W'(TIMER_COUNT - 1));
    assign delay_wide  = 32'(s_tdata[30:7]);
    assign id_in_range = ({1'b0, s_tdata[6:2]} < 6'(TIMER_COUNT));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_step)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        s_tready = 1'b0;
        shift    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_RUN:  shift    = 1'b1;
            ST_FIN:  load_out = !out_valid_reg || m_tready;
            default: s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The entry at the head cell during step k belongs to timer k.
    assign op_ctrl.cmd     = cmd_reg;
    assign op_ctrl.hit     = in_range_reg && (6'(step_reg) == {1'b0, id_reg});
    assign op_ctrl.delay   = delay_reg;
    assign op_ctrl.restart = restart_reg;

    mcst_op u_op (
        .ctrl      (op_ctrl),
        .entry_in  (cell_q[0]),
        .entry_out (op_out),
        .reject    (op_reject)
    );

    genvar gi;
    generate
        for (gi = 0; gi < TIMER_COUNT; gi++)
        begin : g_cell
            entry_t cell_d;
            if (gi == TIMER_COUNT - 1)
            begin : g_tail
                assign cell_d = op_out;
            end
            else
            begin : g_body
                assign cell_d = cell_q[gi+1];
            end

            mcst_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d     (cell_d),
                .q     (cell_q[gi])
            );

            assign pend_vec[gi] = cell_q[gi].pend;
            assign run_vec[gi]  = cell_q[gi].run;
        end
    endgenerate

    always_comb
    begin
        step_next   = step_reg;
        status_next = status_reg;
        if (accept)
        begin
            step_next   = '0;
            // Tick always succeeds; other commands fail at once on a bad id.
            status_next = (cmd_t'(s_tdata[1:0]) != CMD_TICK) && !id_in_range;
        end
        else if (shift)
        begin
            step_next = last_step ? '0 : step_reg + 1'b1;
            if (op_reject)
            begin
                status_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            status_reg <= 1'b0;
        end
        else
        begin
            step_reg   <= step_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= cmd_t'(s_tdata[1:0]);
            id_reg       <= s_tdata[6:2];
            delay_reg    <= delay_wide[COUNT_WIDTH-1:0];
            restart_reg  <= s_tdata[31];
            in_range_reg <= id_in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg <= status_reg;
            out_pend_reg   <= 32'(pend_vec);
            out_run_reg    <= 32'(run_vec);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_run_reg, out_pend_reg, out_status_reg};

endmodule
